// ===== rtl/ptspc_pkg.sv =====
// Package with commands, modes, register indexes, defaults and the entry record of the chooser.
`timescale 1ns / 1ps
package ptspc_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;

   localparam int CMD_W     = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 32;

   localparam logic [1:0] CMD_OBSERVE     = 2'd0;
   localparam logic [1:0] CMD_LOOKUP      = 2'd1;
   localparam logic [1:0] CMD_FORGET_THR  = 2'd2;
   localparam logic [1:0] CMD_FORGET_PROC = 2'd3;

   localparam logic [1:0] MODE_PROBE_PAR = 2'd0;
   localparam logic [1:0] MODE_PROBE_SER = 2'd1;
   localparam logic [1:0] MODE_PAR       = 2'd2;
   localparam logic [1:0] MODE_SER       = 2'd3;

   localparam logic [2:0] CSR_MIN_TPS    = 3'd0;
   localparam logic [2:0] CSR_PROCS      = 3'd1;
   localparam logic [2:0] CSR_SER_THRESH = 3'd2;
   localparam logic [2:0] CSR_SCORE_CEIL = 3'd3;
   localparam logic [2:0] CSR_MIN_SAMPLE = 3'd4;
   localparam logic [2:0] CSR_PROBE_LEN  = 3'd5;
   localparam logic [2:0] CSR_REPROBE    = 3'd6;

   localparam logic [31:0] DEF_MIN_TPS    = 32'd1000;
   localparam logic [6:0]  DEF_PROCS      = 7'd1;
   localparam logic [7:0]  DEF_SER_THRESH = 8'd4;
   localparam logic [7:0]  DEF_SCORE_CEIL = 8'd8;
   localparam logic [31:0] DEF_MIN_SAMPLE = 32'd10000;
   localparam logic [7:0]  DEF_PROBE_LEN  = 8'd4;
   localparam logic [15:0] DEF_REPROBE    = 16'd64;

   localparam logic [6:0] SERIAL_SCALE   = 7'd100;
   localparam logic [6:0] PARALLEL_SCALE = 7'd115;

   typedef struct packed {
      logic [7:0]  score;
      logic [1:0]  mode;
      logic [15:0] stable;
      logic [63:0] st;
      logic [63:0] sn;
      logic [63:0] pt;
      logic [63:0] pn;
      logic [7:0]  ss;
      logic [7:0]  ps;
   } ent_data_type;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [31:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {33'd0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

endpackage

// ===== rtl/per_thread_serial_parallel_chooser_top.sv =====
// Per-thread serial or parallel chooser: keyed history table, sampling and mode decision.
// Every command scans the key memory one entry a cycle; a lookup hit also reads the entry data, and
// an observe that decides a mode does so on the shared 32x32 multiplier.
// One item is in work at a time; the next is taken in the cycle after the result reaches the
// output register. Reset clears all valid bits at once and loads the register defaults.
`timescale 1ns / 1ps
module per_thread_serial_parallel_chooser_top #(
   parameter int TABLE_ENTRIES = ptspc_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ptspc_pkg::CMD_W-1:0]    req_command,
   input  logic [31:0]                    req_thread_number,
   input  logic [31:0]                    req_process_number,
   input  logic [31:0]                    req_slice_ticks,
   input  logic [15:0]                    req_syscall_count,
   input  logic [31:0]                    req_host_nanoseconds,
   input  logic                           req_ran_in_parallel,
   input  logic                           req_was_translated,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_entry_found,
   output logic                           rsp_serialize_now,
   output logic                           rsp_tick_limit_applies,
   output logic [1:0]                     rsp_current_mode,
   output logic                           rsp_table_full,
   input  logic                           csr_we,
   input  logic [ptspc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ptspc_pkg::CSR_W-1:0]    csr_wdata
);
   import ptspc_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int RES_W = 142;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_LOAD, S_DENS, S_MODE, S_MUL, S_CMP, S_WB, S_OUT
   } state_type;

   state_type state_ff;

   logic [31:0] min_tps_ff, min_sample_ff;
   logic [6:0]  procs_ff;
   logic [7:0]  ser_thresh_ff, score_ceil_ff, probe_len_ff;
   logic [15:0] reprobe_ff;

   logic [1:0]  cmd_ff;
   logic [31:0] thr_ff, proc_ff, ticks_ff, ns_ff;
   logic [15:0] svc_ff;
   logic        ranpar_ff, trans_ff;

   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [63:0]  key_mem [TABLE_ENTRIES];
   ent_data_type data_mem [TABLE_ENTRIES];
   logic [63:0]  key_q_ff;
   ent_data_type data_q_ff;

   logic [CNT_W-1:0] scan_ff;
   logic [IDX_W-1:0] chk_ff, hit_ff, free_ff, e_ff;
   logic chk_vld_ff, hit_vld_ff, free_vld_ff, found_ff, new_ff, ent_ff, full_ff, qual_ff;

   ent_data_type w_ff, init_data;

   logic [3:0]       step_ff;
   logic             side_ff;
   logic [127:0]     acc_ff, acc_add;
   logic [RES_W-1:0] res_ff, res_add, lhs_ff;
   logic [63:0]      mul_p_ff;
   logic [31:0]      mul_a, mul_b;
   logic             mul_issue, mul_res, tag_vld_ff, tag_res_ff;
   logic [1:0]       mul_sh, tag_sh_ff, lim;
   logic [6:0]       proc_eff;
   logic [13:0]      kval;
   logic [63:0]      opa, opb;

   logic        rsp_valid_ff, rsp_found_ff, rsp_ser_ff, rsp_tick_ff, rsp_full_ff;
   logic [1:0]  rsp_mode_ff;

   logic        key_hit, key_we, data_rd_en, data_we;
   logic        dense, qual, is_par_mode, hot;
   logic [8:0]  score_inc;
   logic [7:0]  score_nxt;
   logic [15:0] stable_inc;
   logic [7:0]  ps_base, ss_base;
   logic [63:0] pt_base, pn_base, st_base, sn_base;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_entry_found = rsp_found_ff;
   assign rsp_serialize_now = rsp_ser_ff;
   assign rsp_tick_limit_applies = rsp_tick_ff;
   assign rsp_current_mode = rsp_mode_ff;
   assign rsp_table_full = rsp_full_ff;

   assign key_hit = valid_ff[chk_ff] && (key_q_ff == {thr_ff, proc_ff});
   assign key_we = (state_ff == S_DECIDE) && (cmd_ff == CMD_OBSERVE) && !hit_vld_ff
                   && free_vld_ff;
   assign data_rd_en = (state_ff == S_DECIDE);
   assign data_we = (state_ff == S_WB);

   always_comb begin
      init_data = '0;
      init_data.mode = MODE_PROBE_PAR;
   end

   always_comb begin
      dense = (svc_ff != 16'd0) && ({32'd0, ticks_ff} < mul_p_ff);
      score_inc = {1'b0, w_ff.score} + 9'd1;
      if (dense) begin
         score_nxt = (score_inc < {1'b0, score_ceil_ff}) ? score_inc[7:0] : score_ceil_ff;
      end else if (w_ff.score != 8'd0) begin
         score_nxt = w_ff.score - 8'd1;
      end else begin
         score_nxt = w_ff.score;
      end
      is_par_mode = (w_ff.mode == MODE_PAR) || (w_ff.mode == MODE_PROBE_PAR);
      qual = !trans_ff && (svc_ff == 16'd0) && (ticks_ff >= min_sample_ff)
             && (ns_ff != 32'd0) && (ranpar_ff == is_par_mode);
      ps_base = (w_ff.ps == probe_len_ff) ? 8'd0 : w_ff.ps;
      pt_base = (w_ff.ps == probe_len_ff) ? 64'd0 : w_ff.pt;
      pn_base = (w_ff.ps == probe_len_ff) ? 64'd0 : w_ff.pn;
      ss_base = (w_ff.ss == probe_len_ff) ? 8'd0 : w_ff.ss;
      st_base = (w_ff.ss == probe_len_ff) ? 64'd0 : w_ff.st;
      sn_base = (w_ff.ss == probe_len_ff) ? 64'd0 : w_ff.sn;
      stable_inc = w_ff.stable + 16'd1;
      hot = (w_ff.score >= ser_thresh_ff);
   end

   always_comb begin
      proc_eff = (procs_ff == 7'd0) ? 7'd1 : procs_ff;
      kval = side_ff ? (14'(proc_eff) * 14'(PARALLEL_SCALE)) : 14'(SERIAL_SCALE);
      opa = side_ff ? w_ff.pt : w_ff.st;
      opb = side_ff ? w_ff.sn : w_ff.pn;
      lim = 2'(step_ff - 4'd5);
      mul_a = min_tps_ff;
      mul_b = {16'd0, svc_ff};
      mul_issue = 1'b0;
      mul_res = 1'b0;
      mul_sh = 2'd0;
      if (state_ff == S_MUL) begin
         if (step_ff < 4'd4) begin
            mul_a = opa[step_ff[1]*32 +: 32];
            mul_b = opb[step_ff[0]*32 +: 32];
            mul_issue = 1'b1;
            mul_sh = {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
         end else if (step_ff >= 4'd5 && step_ff <= 4'd8) begin
            mul_a = acc_ff[lim*32 +: 32];
            mul_b = {18'd0, kval};
            mul_issue = 1'b1;
            mul_res = 1'b1;
            mul_sh = lim;
         end
      end
      acc_add = acc_ff;
      res_add = res_ff;
      if (tag_vld_ff) begin
         if (tag_res_ff) begin
            res_add = res_ff + (RES_W'(mul_p_ff) << {tag_sh_ff, 5'd0});
         end else begin
            acc_add = acc_ff + (128'(mul_p_ff) << {tag_sh_ff, 5'd0});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[free_ff] <= {thr_ff, proc_ff};
      end
      key_q_ff <= key_mem[scan_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[e_ff] <= w_ff;
      end
      if (data_rd_en) begin
         data_q_ff <= data_mem[hit_ff];
      end
   end

   always_ff @(posedge clock) begin
      mul_p_ff <= mul_a * mul_b;
      tag_vld_ff <= mul_issue;
      tag_res_ff <= mul_res;
      tag_sh_ff <= mul_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff <= '0;
         min_tps_ff <= DEF_MIN_TPS;
         procs_ff <= DEF_PROCS;
         ser_thresh_ff <= DEF_SER_THRESH;
         score_ceil_ff <= DEF_SCORE_CEIL;
         min_sample_ff <= DEF_MIN_SAMPLE;
         probe_len_ff <= DEF_PROBE_LEN;
         reprobe_ff <= DEF_REPROBE;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_MIN_TPS:    min_tps_ff <= csr_wdata;
               CSR_PROCS:      procs_ff <= csr_wdata[6:0];
               CSR_SER_THRESH: ser_thresh_ff <= csr_wdata[7:0];
               CSR_SCORE_CEIL: score_ceil_ff <= csr_wdata[7:0];
               CSR_MIN_SAMPLE: min_sample_ff <= csr_wdata;
               CSR_PROBE_LEN:  probe_len_ff <= csr_wdata[7:0];
               CSR_REPROBE:    reprobe_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff <= req_command;
                  thr_ff <= req_thread_number;
                  proc_ff <= req_process_number;
                  ticks_ff <= req_slice_ticks;
                  svc_ff <= req_syscall_count;
                  ns_ff <= req_host_nanoseconds;
                  ranpar_ff <= req_ran_in_parallel;
                  trans_ff <= req_was_translated;
                  scan_ff <= '0;
                  chk_vld_ff <= 1'b0;
                  hit_vld_ff <= 1'b0;
                  free_vld_ff <= 1'b0;
                  found_ff <= 1'b0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (scan_ff < CNT_W'(TABLE_ENTRIES)) begin
                  scan_ff <= scan_ff + CNT_W'(1);
               end
               chk_vld_ff <= (scan_ff < CNT_W'(TABLE_ENTRIES));
               chk_ff <= scan_ff[IDX_W-1:0];
               if (chk_vld_ff) begin
                  if (cmd_ff == CMD_FORGET_PROC) begin
                     if (valid_ff[chk_ff] && key_q_ff[31:0] == proc_ff) begin
                        valid_ff[chk_ff] <= 1'b0;
                        found_ff <= 1'b1;
                     end
                  end else if (key_hit) begin
                     hit_vld_ff <= 1'b1;
                     hit_ff <= chk_ff;
                  end
                  if (!valid_ff[chk_ff] && !free_vld_ff) begin
                     free_vld_ff <= 1'b1;
                     free_ff <= chk_ff;
                  end
                  if (chk_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
                     state_ff <= S_DECIDE;
                  end
               end
            end
            S_DECIDE: begin
               new_ff <= 1'b0;
               ent_ff <= 1'b0;
               full_ff <= 1'b0;
               e_ff <= hit_ff;
               state_ff <= S_OUT;
               case (cmd_ff)
                  CMD_OBSERVE: begin
                     found_ff <= hit_vld_ff;
                     if (hit_vld_ff) begin
                        ent_ff <= 1'b1;
                        state_ff <= S_LOAD;
                     end else if (free_vld_ff) begin
                        e_ff <= free_ff;
                        new_ff <= 1'b1;
                        ent_ff <= 1'b1;
                        valid_ff[free_ff] <= 1'b1;
                        state_ff <= S_LOAD;
                     end else begin
                        full_ff <= 1'b1;
                     end
                  end
                  CMD_LOOKUP: begin
                     found_ff <= hit_vld_ff;
                     if (hit_vld_ff) begin
                        ent_ff <= 1'b1;
                        state_ff <= S_LOAD;
                     end
                  end
                  CMD_FORGET_THR: begin
                     found_ff <= hit_vld_ff;
                     if (hit_vld_ff) begin
                        valid_ff[hit_ff] <= 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
            S_LOAD: begin
               w_ff <= new_ff ? init_data : data_q_ff;
               state_ff <= (cmd_ff == CMD_OBSERVE) ? S_DENS : S_OUT;
            end
            S_DENS: begin
               w_ff.score <= score_nxt;
               qual_ff <= qual;
               if (qual) begin
                  if (ranpar_ff) begin
                     w_ff.pt <= sat_add(pt_base, ticks_ff);
                     w_ff.pn <= sat_add(pn_base, ns_ff);
                     w_ff.ps <= ps_base + 8'd1;
                  end else begin
                     w_ff.st <= sat_add(st_base, ticks_ff);
                     w_ff.sn <= sat_add(sn_base, ns_ff);
                     w_ff.ss <= ss_base + 8'd1;
                  end
               end
               state_ff <= S_MODE;
            end
            S_MODE: begin
               state_ff <= S_WB;
               step_ff <= 4'd0;
               side_ff <= 1'b0;
               acc_ff <= '0;
               res_ff <= '0;
               if (qual_ff) begin
                  if (w_ff.mode == MODE_PROBE_PAR && w_ff.ps == probe_len_ff) begin
                     if (w_ff.ss == 8'd0) begin
                        w_ff.mode <= MODE_PROBE_SER;
                     end else begin
                        state_ff <= S_MUL;
                     end
                  end else if (w_ff.mode == MODE_PROBE_SER && w_ff.ss == probe_len_ff) begin
                     state_ff <= S_MUL;
                  end else if (w_ff.mode == MODE_PAR || w_ff.mode == MODE_SER) begin
                     if (stable_inc >= reprobe_ff) begin
                        w_ff.stable <= 16'd0;
                        if (w_ff.mode == MODE_PAR) begin
                           w_ff.st <= '0;
                           w_ff.sn <= '0;
                           w_ff.ss <= '0;
                           w_ff.mode <= MODE_PROBE_SER;
                        end else begin
                           w_ff.pt <= '0;
                           w_ff.pn <= '0;
                           w_ff.ps <= '0;
                           w_ff.mode <= MODE_PROBE_PAR;
                        end
                     end else begin
                        w_ff.stable <= stable_inc;
                     end
                  end
               end
            end
            S_MUL: begin
               acc_ff <= acc_add;
               res_ff <= res_add;
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'd9) begin
                  if (!side_ff) begin
                     lhs_ff <= res_add;
                     res_ff <= '0;
                     acc_ff <= '0;
                     side_ff <= 1'b1;
                     step_ff <= 4'd0;
                  end else begin
                     state_ff <= S_CMP;
                  end
               end
            end
            S_CMP: begin
               w_ff.mode <= (lhs_ff > res_ff) ? MODE_SER : MODE_PAR;
               w_ff.stable <= 16'd0;
               state_ff <= S_WB;
            end
            S_WB: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_found_ff <= found_ff;
                  rsp_full_ff <= full_ff;
                  if (ent_ff) begin
                     rsp_ser_ff <= hot || w_ff.mode == MODE_PROBE_SER || w_ff.mode == MODE_SER;
                     rsp_tick_ff <= hot || w_ff.mode == MODE_PROBE_PAR
                                    || w_ff.mode == MODE_PROBE_SER;
                     rsp_mode_ff <= w_ff.mode;
                  end else begin
                     rsp_ser_ff <= 1'b0;
                     rsp_tick_ff <= 1'b1;
                     rsp_mode_ff <= MODE_PROBE_PAR;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_full_only_when_no_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && cmd_ff == CMD_OBSERVE && !hit_vld_ff && !free_vld_ff)
      |-> (&valid_ff))
      else $error("table reported full while an entry was free");

   a_forget_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && cmd_ff == CMD_FORGET_THR && hit_vld_ff)
      |=> !valid_ff[hit_ff])
      else $error("forgotten entry is still valid");

   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_full_ff) |-> (!rsp_found_ff && rsp_mode_ff == MODE_PROBE_PAR))
      else $error("dropped observe item reports an entry");
`endif

endmodule

// ===== tb/sv/per_thread_serial_parallel_chooser_top_tb.sv =====
// Self-checking testbench for the per-thread serial or parallel chooser with a built-in predictor.
`timescale 1ns / 1ps
module per_thread_serial_parallel_chooser_top_tb;
   import ptspc_pkg::*;

   localparam int SLOTS = 64;

   typedef struct {
      logic [1:0]  cmd;
      logic [31:0] thr;
      logic [31:0] proc;
      logic [31:0] ticks;
      logic [15:0] svc;
      logic [31:0] ns;
      logic        par;
      logic        trans;
   } slice_item_type;

   typedef struct {
      logic       found;
      logic       ser;
      logic       limit;
      logic [1:0] mode;
      logic       full;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = '0;
   logic [31:0] req_thread_number = '0;
   logic [31:0] req_process_number = '0;
   logic [31:0] req_slice_ticks = '0;
   logic [15:0] req_syscall_count = '0;
   logic [31:0] req_host_nanoseconds = '0;
   logic        req_ran_in_parallel = 1'b0;
   logic        req_was_translated = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_entry_found;
   logic        rsp_serialize_now;
   logic        rsp_tick_limit_applies;
   logic [1:0]  rsp_current_mode;
   logic        rsp_table_full;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   slice_item_type pending_slices[$];
   verdict_type    expected_verdicts[$];
   slice_item_type current_slice;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          failures = 0;

   // Predictor copy of the registers and the history table.
   logic [31:0] cfg_min_tps;
   logic [6:0]  cfg_procs;
   logic [7:0]  cfg_thresh;
   logic [7:0]  cfg_ceil;
   logic [31:0] cfg_min_sample;
   logic [7:0]  cfg_probe_len;
   logic [15:0] cfg_reprobe;

   logic        slot_valid[SLOTS];
   logic [31:0] slot_thread[SLOTS];
   logic [31:0] slot_process[SLOTS];
   logic [7:0]  slot_score[SLOTS];
   logic [1:0]  slot_mode[SLOTS];
   logic [15:0] slot_stable[SLOTS];
   logic [63:0] ser_ticks[SLOTS];
   logic [63:0] ser_ns[SLOTS];
   logic [7:0]  ser_cnt[SLOTS];
   logic [63:0] par_ticks[SLOTS];
   logic [63:0] par_ns[SLOTS];
   logic [7:0]  par_cnt[SLOTS];

   per_thread_serial_parallel_chooser_top DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [63:0] add_capped(logic [63:0] a, logic [31:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {33'd0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   function automatic void decide_mode(int e);
      logic [191:0] lhs;
      logic [191:0] rhs;
      logic [191:0] scale;
      scale = (cfg_procs == 0) ? 192'd115 : 192'(cfg_procs) * 192'd115;
      lhs = 192'(ser_ticks[e]) * 192'(par_ns[e]) * 192'd100;
      rhs = 192'(par_ticks[e]) * 192'(ser_ns[e]) * scale;
      slot_mode[e] = (lhs > rhs) ? MODE_SER : MODE_PAR;
      slot_stable[e] = '0;
   endfunction

   function automatic void apply_slice(int e, slice_item_type it);
      logic [1:0] m;
      logic [8:0] bumped;
      logic       dense;
      m = slot_mode[e];
      dense = (it.svc != 0) && ((it.ticks / {16'd0, it.svc}) < cfg_min_tps);
      if (dense) begin
         bumped = {1'b0, slot_score[e]} + 9'd1;
         slot_score[e] = (bumped < {1'b0, cfg_ceil}) ? bumped[7:0] : cfg_ceil;
      end else if (slot_score[e] != 0) begin
         slot_score[e] = slot_score[e] - 8'd1;
      end
      if (it.trans || it.svc != 0 || it.ticks < cfg_min_sample || it.ns == 0) return;
      if (it.par != (m == MODE_PAR || m == MODE_PROBE_PAR)) return;
      if (it.par) begin
         if (par_cnt[e] == cfg_probe_len) begin
            par_ticks[e] = '0; par_ns[e] = '0; par_cnt[e] = '0;
         end
         par_ticks[e] = add_capped(par_ticks[e], it.ticks);
         par_ns[e] = add_capped(par_ns[e], it.ns);
         par_cnt[e] = par_cnt[e] + 8'd1;
      end else begin
         if (ser_cnt[e] == cfg_probe_len) begin
            ser_ticks[e] = '0; ser_ns[e] = '0; ser_cnt[e] = '0;
         end
         ser_ticks[e] = add_capped(ser_ticks[e], it.ticks);
         ser_ns[e] = add_capped(ser_ns[e], it.ns);
         ser_cnt[e] = ser_cnt[e] + 8'd1;
      end
      if (m == MODE_PROBE_PAR && par_cnt[e] == cfg_probe_len) begin
         if (ser_cnt[e] == 0) slot_mode[e] = MODE_PROBE_SER;
         else decide_mode(e);
      end else if (m == MODE_PROBE_SER && ser_cnt[e] == cfg_probe_len) begin
         decide_mode(e);
      end else if (m == MODE_PAR || m == MODE_SER) begin
         slot_stable[e] = slot_stable[e] + 16'd1;
         if (slot_stable[e] >= cfg_reprobe) begin
            slot_stable[e] = '0;
            if (m == MODE_PAR) begin
               ser_ticks[e] = '0; ser_ns[e] = '0; ser_cnt[e] = '0;
               slot_mode[e] = MODE_PROBE_SER;
            end else begin
               par_ticks[e] = '0; par_ns[e] = '0; par_cnt[e] = '0;
               slot_mode[e] = MODE_PROBE_PAR;
            end
         end
      end
   endfunction

   function automatic verdict_type predict_verdict(slice_item_type it);
      verdict_type r;
      int e;
      logic hot;
      e = -1;
      r = '{1'b0, 1'b0, 1'b1, MODE_PROBE_PAR, 1'b0};
      for (int i = 0; i < SLOTS; i++)
         if (e < 0 && slot_valid[i] && slot_thread[i] == it.thr && slot_process[i] == it.proc)
            e = i;
      case (it.cmd)
         CMD_OBSERVE: begin
            r.found = (e >= 0);
            if (e < 0) begin
               for (int i = 0; i < SLOTS; i++)
                  if (e < 0 && !slot_valid[i]) e = i;
               if (e >= 0) begin
                  slot_valid[e] = 1'b1;
                  slot_thread[e] = it.thr;
                  slot_process[e] = it.proc;
                  slot_score[e] = '0;
                  slot_mode[e] = MODE_PROBE_PAR;
                  slot_stable[e] = '0;
                  ser_ticks[e] = '0; ser_ns[e] = '0; ser_cnt[e] = '0;
                  par_ticks[e] = '0; par_ns[e] = '0; par_cnt[e] = '0;
               end else begin
                  r.full = 1'b1;
               end
            end
            if (e >= 0) apply_slice(e, it);
         end
         CMD_LOOKUP: r.found = (e >= 0);
         CMD_FORGET_THR: begin
            r.found = (e >= 0);
            if (e >= 0) slot_valid[e] = 1'b0;
            e = -1;
         end
         default: begin
            for (int i = 0; i < SLOTS; i++)
               if (slot_valid[i] && slot_process[i] == it.proc) begin
                  slot_valid[i] = 1'b0;
                  r.found = 1'b1;
               end
            e = -1;
         end
      endcase
      if (e >= 0) begin
         hot = slot_score[e] >= cfg_thresh;
         r.ser = hot || slot_mode[e] == MODE_PROBE_SER || slot_mode[e] == MODE_SER;
         r.limit = hot || slot_mode[e] == MODE_PROBE_PAR || slot_mode[e] == MODE_PROBE_SER;
         r.mode = slot_mode[e];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_verdicts.push_back(predict_verdict(current_slice));
         if (!req_valid || !req_stall) begin
            if (pending_slices.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               current_slice = pending_slices.pop_front();
               req_command <= current_slice.cmd;
               req_thread_number <= current_slice.thr;
               req_process_number <= current_slice.proc;
               req_slice_ticks <= current_slice.ticks;
               req_syscall_count <= current_slice.svc;
               req_host_nanoseconds <= current_slice.ns;
               req_ran_in_parallel <= current_slice.par;
               req_was_translated <= current_slice.trans;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               $error("unexpected result item");
               failures++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_entry_found !== want.found) begin
                  $error("entry_found: expected %0d, actual %0d", want.found, rsp_entry_found);
                  failures++;
               end
               if (rsp_serialize_now !== want.ser) begin
                  $error("serialize_now: expected %0d, actual %0d", want.ser, rsp_serialize_now);
                  failures++;
               end
               if (rsp_tick_limit_applies !== want.limit) begin
                  $error("tick_limit_applies: expected %0d, actual %0d", want.limit,
                         rsp_tick_limit_applies);
                  failures++;
               end
               if (rsp_current_mode !== want.mode) begin
                  $error("current_mode: expected %0d, actual %0d", want.mode, rsp_current_mode);
                  failures++;
               end
               if (rsp_table_full !== want.full) begin
                  $error("table_full: expected %0d, actual %0d", want.full, rsp_table_full);
                  failures++;
               end
            end
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_MIN_TPS:    cfg_min_tps = value;
         CSR_PROCS:      cfg_procs = value[6:0];
         CSR_SER_THRESH: cfg_thresh = value[7:0];
         CSR_SCORE_CEIL: cfg_ceil = value[7:0];
         CSR_MIN_SAMPLE: cfg_min_sample = value;
         CSR_PROBE_LEN:  cfg_probe_len = value[7:0];
         CSR_REPROBE:    cfg_reprobe = value[15:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_regs(logic [31:0] tps, logic [31:0] procs, logic [31:0] thresh,
                           logic [31:0] ceil, logic [31:0] sample, logic [31:0] probe,
                           logic [31:0] reprobe);
      write_reg(CSR_MIN_TPS, tps);
      write_reg(CSR_PROCS, procs);
      write_reg(CSR_SER_THRESH, thresh);
      write_reg(CSR_SCORE_CEIL, ceil);
      write_reg(CSR_MIN_SAMPLE, sample);
      write_reg(CSR_PROBE_LEN, probe);
      write_reg(CSR_REPROBE, reprobe);
   endtask

   task automatic push_slice(logic [1:0] cmd, logic [31:0] thr, logic [31:0] proc,
                             logic [31:0] ticks, logic [15:0] svc, logic [31:0] ns,
                             logic par, logic trans);
      slice_item_type it;
      it = '{cmd, thr, proc, ticks, svc, ns, par, trans};
      pending_slices.push_back(it);
   endtask

   task automatic push_random_slices(int count, int fresh_pct);
      slice_item_type it;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            it = '{2'($urandom), $urandom, $urandom, $urandom, 16'($urandom), $urandom,
                   1'($urandom), 1'($urandom)};
         end else begin
            pick = $urandom_range(0, 99);
            it.cmd = (pick < 84) ? CMD_OBSERVE : (pick < 92) ? CMD_LOOKUP :
                     (pick < 97) ? CMD_FORGET_THR : CMD_FORGET_PROC;
            it.thr = ($urandom_range(0, 99) < fresh_pct) ? $urandom : $urandom_range(0, 7);
            it.proc = ($urandom_range(0, 99) < fresh_pct) ? $urandom : $urandom_range(0, 2);
            it.par = 1'($urandom);
            it.trans = ($urandom_range(0, 19) == 0);
            it.ns = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 20000) : $urandom;
            if ($urandom_range(0, 3) == 0) begin
               it.svc = 16'($urandom_range(1, 65535));
               it.ticks = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000000);
            end else begin
               it.svc = '0;
               it.ticks = (cfg_min_sample > 32'hFFFF0000) ? 32'hFFFFFFFF :
                          cfg_min_sample + $urandom_range(0, 60000);
            end
         end
         pending_slices.push_back(it);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_slices.size() != 0 || req_valid || expected_verdicts.size() != 0);
      repeat (120) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
      cfg_min_tps = DEF_MIN_TPS;
      cfg_procs = DEF_PROCS;
      cfg_thresh = DEF_SER_THRESH;
      cfg_ceil = DEF_SCORE_CEIL;
      cfg_min_sample = DEF_MIN_SAMPLE;
      cfg_probe_len = DEF_PROBE_LEN;
      cfg_reprobe = DEF_REPROBE;
      send_idle_pct = 37;
      recv_idle_pct = 61;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_slice(CMD_LOOKUP, 32'd0, 32'd0, '0, '0, '0, 1'b0, 1'b0);
      push_slice(CMD_OBSERVE, 32'd0, 32'd0, 32'd0, 16'd0, 32'd0, 1'b0, 1'b0);
      push_slice(CMD_OBSERVE, '1, '1, '1, '1, '1, 1'b1, 1'b1);
      push_slice(CMD_LOOKUP, '1, '1, '0, '0, '0, 1'b0, 1'b0);
      for (int k = 0; k < 4; k++)
         push_slice(CMD_OBSERVE, 32'd5, 32'd1, 32'd10, 16'd1, 32'd50, 1'b0, 1'b0);
      for (int k = 0; k < 4; k++)
         push_slice(CMD_OBSERVE, 32'd1, 32'd1, 32'd20000, 16'd0, 32'd9000, 1'b1, 1'b0);
      for (int k = 0; k < 4; k++)
         push_slice(CMD_OBSERVE, 32'd1, 32'd1, 32'd20000, 16'd0, 32'd3000, 1'b0, 1'b0);
      push_slice(CMD_OBSERVE, 32'd1, 32'd1, 32'd20000, 16'd0, 32'd0, 1'b1, 1'b0);
      push_slice(CMD_OBSERVE, 32'd1, 32'd1, 32'd9999, 16'd0, 32'd100, 1'b1, 1'b0);
      push_slice(CMD_OBSERVE, 32'd1, 32'd1, 32'd20000, 16'd0, 32'd100, 1'b1, 1'b1);
      push_slice(CMD_FORGET_THR, 32'd1, 32'd1, '0, '0, '0, 1'b0, 1'b0);
      push_slice(CMD_FORGET_THR, 32'd1, 32'd1, '0, '0, '0, 1'b0, 1'b0);
      push_slice(CMD_FORGET_PROC, '1, 32'd1, '0, '0, '0, 1'b0, 1'b0);
      push_slice(CMD_FORGET_PROC, 32'd0, 32'd7, '0, '0, '0, 1'b0, 1'b0);
      push_slice(CMD_LOOKUP, 32'd5, 32'd1, '0, '0, '0, 1'b0, 1'b0);
      wait_drained();

      set_regs(32'd1000, 32'd1, 32'd4, 32'd8, 32'd10000, 32'd1, 32'd1);
      @(negedge clock);
      push_random_slices(150, 5);
      wait_drained();

      set_regs(32'hFFFFFFFF, 32'd64, 32'd0, 32'd0, 32'd1, 32'd2, 32'd3);
      @(negedge clock);
      push_random_slices(150, 5);
      wait_drained();

      send_idle_pct = 61;
      recv_idle_pct = 37;
      set_regs(32'd1, 32'd2, 32'd255, 32'd255, 32'hFFFFFFFF, 32'd255, 32'd65535);
      @(negedge clock);
      push_random_slices(100, 5);
      wait_drained();

      set_regs(32'd500, 32'd7, 32'd2, 32'd5, 32'd100, 32'd3, 32'd5);
      @(negedge clock);
      for (int k = 0; k < 70; k++)
         push_slice(CMD_OBSERVE, 32'd1000 + k, 32'd9, $urandom, 16'($urandom_range(0, 3)),
                    $urandom, 1'($urandom), 1'b0);
      push_random_slices(80, 30);
      push_slice(CMD_FORGET_PROC, 32'd0, 32'd9, '0, '0, '0, 1'b0, 1'b0);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_regs(32'd2000, 32'd33, 32'd3, 32'd6, 32'd5000, 32'd2, 32'd4);
      @(negedge clock);
      push_random_slices(175, 5);
      wait_drained();

      if (failures == 0 && expected_verdicts.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== per_thread_serial_parallel_chooser_top.f =====
rtl/ptspc_pkg.sv
rtl/per_thread_serial_parallel_chooser_top.sv
tb/sv/per_thread_serial_parallel_chooser_top_tb.sv
